FILE: hdl/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg: shared types and constants for the camera ray direction block
// widths of the fixed point fields, register codes and pipeline records
// ----------------------------------------------------------------------------
`default_nettype none

package crd_pkg;

   // field widths
   localparam int SCREEN_W = 16;
   localparam int DIR_W    = 16;
   localparam int COMP_W   = 20;
   localparam int VEC_W    = 3 * COMP_W;
   localparam int CSR_IDX_W = 2;

   // internal widths
   localparam int PROD_W = SCREEN_W + COMP_W;   // screen times axis component
   localparam int ACC_W  = PROD_W + 2;          // accumulated Q.28 sum
   localparam int V_W    = ACC_W - 14 - 1;      // rounded Q.14 component, signed
   localparam int MAG_W  = V_W - 1;             // magnitude of a component
   localparam int SQ_W   = 2 * MAG_W;
   localparam int SUM_W  = SQ_W + 2;
   localparam int PAIRS  = SUM_W / 2;
   localparam int PAIR_W = 5;
   localparam int K_W    = 6;
   localparam int FPROD_W = MAG_W + 32;

   // normalized mantissa has its top nonzero bit pair here
   localparam int NORM_PAIR = 15;

   // default Newton step count
   localparam int RSQRT_ITERATIONS_DEF = 3;

   // reciprocal of three, exact for 32-bit dividends with a shift of 33
   localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
   localparam logic [33:0] SEVEN_Q30 = 34'd7 << 30;
   localparam logic [33:0] THREE_Q30 = 34'd3 << 30;
   localparam logic [DIR_W-1:0] DIR_ONE = DIR_W'(16384);

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FORWARD = 2'd0,
      REG_RIGHT   = 2'd1,
      REG_UP      = 2'd2
   } reg_idx_type;

   // per-item data that rides along the pipeline
   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic [PAIR_W-1:0]     pair;
      logic                  deg;
   } side_type;

   // one Newton pipeline stage record
   typedef struct packed {
      logic        vld;
      logic [31:0] m;
      logic [31:0] y;
      logic [31:0] aux;
      side_type    side;
   } nw_type;

endpackage

`default_nettype wire

FILE: hdl/camera_ray_direction_top.sv
// ----------------------------------------------------------------------------
// camera_ray_direction_top: pinhole camera ray direction pipeline
// forms forward - x*right - y*up and scales it to unit length
// ----------------------------------------------------------------------------
// Usage
//   Input: a beat is taken when start is high and busy is low. busy is only
//   high during reset, so one screen coordinate pair can enter every cycle.
//   Output: each result sits on the rsp_ ports for one cycle with rsp_valid
//   high; the receiver cannot stall, so nothing is held back.
//   Pipeline: a product stage, an accumulate and round stage, square and
//   sum, leading-pair search, normalize shift, seed divide, three
//   multiplies per Newton step, then the final scale and round.
//   Throughput: one item per cycle.
//   Configuration: the csr_ channel is always ready; index 0 forward vector,
//   1 right axis, 2 up axis, others ignored. Write only while the pipeline
//   is empty.
//   Reset: clears the configuration registers and all valid bits; in-flight items are lost.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_ray_direction_top #(
   parameter int RSQRT_ITERATIONS = crd_pkg::RSQRT_ITERATIONS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic signed [crd_pkg::SCREEN_W-1:0]  req_screen_x,
   input  wire logic signed [crd_pkg::SCREEN_W-1:0]  req_screen_y,
   output logic                                      rsp_valid,
   output logic signed [crd_pkg::DIR_W-1:0]          rsp_dir_x,
   output logic signed [crd_pkg::DIR_W-1:0]          rsp_dir_y,
   output logic signed [crd_pkg::DIR_W-1:0]          rsp_dir_z,
   output logic                                      rsp_degenerate,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [crd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [crd_pkg::VEC_W-1:0]            csr_data
);
   import crd_pkg::*;

   localparam int NI = RSQRT_ITERATIONS;

   // configuration registers
   logic [VEC_W-1:0] fwd_ff, rgt_ff, up_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= '0;
         rgt_ff <= '0;
         up_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (reg_idx_type'(csr_index))
            REG_FORWARD: fwd_ff <= csr_data;
            REG_RIGHT:   rgt_ff <= csr_data;
            REG_UP:      up_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = reset;

   logic accept;
   assign accept = start && !busy;

   // stage 1: screen times axis products
   logic                     s1_vld_ff;
   logic signed [PROD_W-1:0] s1_pr_ff [3];
   logic signed [PROD_W-1:0] s1_pu_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else       s1_vld_ff <= accept;
      for (int c = 0; c < 3; c++) begin
         s1_pr_ff[c] <= req_screen_x * $signed(rgt_ff[COMP_W*c +: COMP_W]);
         s1_pu_ff[c] <= req_screen_y * $signed(up_ff[COMP_W*c +: COMP_W]);
      end
   end

   // stage 2: accumulate and round to Q.14, split sign and magnitude
   logic     s2_vld_ff;
   side_type s2_side_ff, s2_side_in;

   always_comb begin
      logic signed [ACC_W-1:0] acc;
      logic signed [V_W-1:0]   v;
      s2_side_in = '0;
      for (int c = 0; c < 3; c++) begin
         acc = ACC_W'($signed(fwd_ff[COMP_W*c +: COMP_W])) <<< 14;
         acc = acc - ACC_W'(s1_pr_ff[c]) - ACC_W'(s1_pu_ff[c])
               + ACC_W'(signed'(1 <<< 13));
         v = acc[ACC_W-2:14];
         s2_side_in.neg[c] = v[V_W-1];
         s2_side_in.mag[c] = v[V_W-1] ? MAG_W'(-v) : MAG_W'(v);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else       s2_vld_ff <= s1_vld_ff;
      s2_side_ff <= s2_side_in;
   end

   // stage 3: squares
   logic            s3_vld_ff;
   side_type        s3_side_ff;
   logic [SQ_W-1:0] s3_sq_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else       s3_vld_ff <= s2_vld_ff;
      s3_side_ff <= s2_side_ff;
      for (int c = 0; c < 3; c++)
         s3_sq_ff[c] <= s2_side_ff.mag[c] * s2_side_ff.mag[c];
   end

   // stage 4: squared length
   logic             s4_vld_ff;
   side_type         s4_side_ff;
   logic [SUM_W-1:0] s4_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else       s4_vld_ff <= s3_vld_ff;
      s4_side_ff <= s3_side_ff;
      s4_sum_ff  <= SUM_W'(s3_sq_ff[0]) + SUM_W'(s3_sq_ff[1]) + SUM_W'(s3_sq_ff[2]);
   end

   // stage 5: leading nonzero bit pair, zero detect
   logic             s5_vld_ff;
   side_type         s5_side_ff, s5_side_in;
   logic [SUM_W-1:0] s5_sum_ff;

   always_comb begin
      s5_side_in      = s4_side_ff;
      s5_side_in.pair = '0;
      for (int i = 0; i < PAIRS; i++)
         if (s4_sum_ff[2*i +: 2] != 2'b00) s5_side_in.pair = PAIR_W'(i);
      s5_side_in.deg = (s4_sum_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else       s5_vld_ff <= s4_vld_ff;
      s5_side_ff <= s5_side_in;
      s5_sum_ff  <= s4_sum_ff;
   end

   // stage 6: normalize to Q2.30 in [1,4)
   logic        s6_vld_ff;
   side_type    s6_side_ff;
   logic [31:0] s6_m_ff, s6_m_in;

   always_comb begin
      logic [63:0] mw;
      mw = 64'(s5_sum_ff);
      if (s5_side_ff.pair >= PAIR_W'(NORM_PAIR))
         mw = mw >> {s5_side_ff.pair - PAIR_W'(NORM_PAIR), 1'b0};
      else
         mw = mw << {PAIR_W'(NORM_PAIR) - s5_side_ff.pair, 1'b0};
      s6_m_in = mw[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) s6_vld_ff <= 1'b0;
      else       s6_vld_ff <= s5_vld_ff;
      s6_side_ff <= s5_side_ff;
      s6_m_ff    <= s6_m_in;
   end

   // stage 7: seed (7 - m) / 6 via reciprocal of three
   nw_type seed_ff, seed_in;

   always_comb begin
      logic [33:0] x;
      logic [63:0] q;
      x = SEVEN_Q30 - {2'b00, s6_m_ff};
      q = x[32:1] * RECIP3;
      seed_in.vld  = s6_vld_ff;
      seed_in.m    = s6_m_ff;
      seed_in.y    = {1'b0, q[63:33]};
      seed_in.aux  = '0;
      seed_in.side = s6_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) seed_ff <= '0;
      else       seed_ff <= seed_in;
   end

   // Newton steps, three stages each: t = y*y, w = 3 - m*t, y = y*w/2
   nw_type nw_ff [NI+1];
   assign nw_ff[0] = seed_ff;

   for (genvar i = 0; i < NI; i++) begin : g_newton
      nw_type a_ff, a_in, b_ff, b_in, c_ff, c_in;

      always_comb begin
         logic [63:0] p;
         p      = nw_ff[i].y * nw_ff[i].y;
         a_in   = nw_ff[i];
         a_in.aux = p[61:30];
      end

      always_comb begin
         logic [63:0] p;
         logic [33:0] u;
         p    = a_ff.m * a_ff.aux;
         u    = p[63:30];
         b_in = a_ff;
         b_in.aux = (u >= THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - u);
      end

      always_comb begin
         logic [63:0] p;
         p    = b_ff.y * b_ff.aux;
         c_in = b_ff;
         c_in.y = p[62:31];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            a_ff <= '0;
            b_ff <= '0;
            c_ff <= '0;
         end else begin
            a_ff <= a_in;
            b_ff <= b_in;
            c_ff <= c_in;
         end
      end

      assign nw_ff[i+1] = c_ff;
   end

   // final scale: magnitude times reciprocal root
   logic               f1_vld_ff;
   side_type           f1_side_ff;
   logic [FPROD_W-1:0] f1_prod_ff [3];

   always_ff @(posedge clock) begin
      if (reset) f1_vld_ff <= 1'b0;
      else       f1_vld_ff <= nw_ff[NI].vld;
      f1_side_ff <= nw_ff[NI].side;
      for (int c = 0; c < 3; c++)
         f1_prod_ff[c] <= nw_ff[NI].side.mag[c] * nw_ff[NI].y;
   end

   // output beat: round half away from zero, clamp, apply sign; zero if degenerate
   logic                    out_vld_ff;
   logic                    out_deg_ff;
   logic signed [DIR_W-1:0] out_dir_ff [3];
   logic signed [DIR_W-1:0] out_dir_in [3];

   always_comb begin
      logic [K_W-1:0]     k;
      logic [FPROD_W:0]   sum;
      logic [FPROD_W:0]   r;
      logic [DIR_W-1:0]   rc;
      k = K_W'(f1_side_ff.pair) + K_W'(NORM_PAIR + 1);
      for (int c = 0; c < 3; c++) begin
         sum = (FPROD_W+1)'(f1_prod_ff[c]) + ((FPROD_W+1)'(1) << (k - K_W'(1)));
         r   = sum >> k;
         rc  = (r > (FPROD_W+1)'(DIR_ONE)) ? DIR_ONE : r[DIR_W-1:0];
         if (f1_side_ff.deg)         out_dir_in[c] = '0;
         else if (f1_side_ff.neg[c]) out_dir_in[c] = -$signed(rc);
         else                        out_dir_in[c] = $signed(rc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else       out_vld_ff <= f1_vld_ff;
      out_deg_ff <= f1_side_ff.deg;
      for (int c = 0; c < 3; c++) out_dir_ff[c] <= out_dir_in[c];
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_degenerate = out_deg_ff;
   assign rsp_dir_x      = out_dir_ff[0];
   assign rsp_dir_y      = out_dir_ff[1];
   assign rsp_dir_z      = out_dir_ff[2];

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for camera_ray_direction_top
// drives screen coordinate pairs under several camera setups, predicts each
// unit ray direction in fixed point and checks every result in arrival order
// ----------------------------------------------------------------------------

module tb;
   import crd_pkg::*;

   localparam int     NEWTON_STEPS = RSQRT_ITERATIONS_DEF;
   localparam int     DRAIN_CYCLES = 40;
   localparam longint CYCLE_LIMIT  = 200000;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam longint unsigned ONE_Q30 = 64'd1 << 30;

   typedef struct packed {
      logic signed [DIR_W-1:0] dx;
      logic signed [DIR_W-1:0] dy;
      logic signed [DIR_W-1:0] dz;
      logic                    deg;
   } ray_dir_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic signed [SCREEN_W-1:0]   req_screen_x = '0;
   logic signed [SCREEN_W-1:0]   req_screen_y = '0;
   logic                         rsp_valid;
   logic signed [DIR_W-1:0]      rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic                         rsp_degenerate;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [VEC_W-1:0]             csr_data = '0;

   // camera registers as the bench sees them
   logic [VEC_W-1:0] cam_forward = '0;
   logic [VEC_W-1:0] cam_right   = '0;
   logic [VEC_W-1:0] cam_up      = '0;

   ray_dir_type pending_dirs[$];
   int       mismatch_count = 0;
   int       send_gap_pct   = 0;
   longint   cycle_count    = 0;

   camera_ray_direction_top #(
      .RSQRT_ITERATIONS(NEWTON_STEPS)
   ) dut (
      .clock, .reset, .start, .busy, .req_screen_x, .req_screen_y,
      .rsp_valid, .rsp_dir_x, .rsp_dir_y, .rsp_dir_z, .rsp_degenerate,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always #4 clock = ~clock;

   // signed Q5.14 component c of a packed vector
   function automatic longint vec_comp(logic [VEC_W-1:0] vec, int c);
      logic signed [COMP_W-1:0] f;
      f = vec[COMP_W*c +: COMP_W];
      return longint'(f);
   endfunction

   // expected unit direction for one screen coordinate pair
   function automatic ray_dir_type predict_dir(logic signed [SCREEN_W-1:0] sx,
                                               logic signed [SCREEN_W-1:0] sy);
      longint acc;
      longint v[3];
      longint unsigned mag[3];
      longint unsigned s, m, y, t, u, w, r;
      int sh, k;
      ray_dir_type d;
      logic signed [DIR_W-1:0] comp_out[3];
      s = 0;
      for (int c = 0; c < 3; c++) begin
         acc = vec_comp(cam_forward, c) * 16384
             - longint'(sx) * vec_comp(cam_right, c)
             - longint'(sy) * vec_comp(cam_up, c);
         v[c] = (acc + 8192) >>> 14;
         mag[c] = (v[c] < 0) ? longint'(-v[c]) : longint'(v[c]);
         s += mag[c] * mag[c];
      end
      if (s == 0) begin
         d = '{dx: '0, dy: '0, dz: '0, deg: 1'b1};
         return d;
      end
      // normalize to Q2.30 in [1, 4) by even shifts
      m = s;
      sh = 0;
      while (m >= (64'd1 << 32)) begin
         m >>= 2;
         sh -= 2;
      end
      while (m < ONE_Q30) begin
         m <<= 2;
         sh += 2;
      end
      // linear seed then Newton refinement of 1/sqrt(m)
      y = (7 * ONE_Q30 - m) / 6;
      for (int i = 0; i < NEWTON_STEPS; i++) begin
         t = (y * y) >> 30;
         u = (m * t) >> 30;
         w = (u >= 3 * ONE_Q30) ? 64'd0 : 3 * ONE_Q30 - u;
         y = (y * w) >> 31;
      end
      // scale, round half away from zero, clamp to one
      k = 31 - sh / 2;
      for (int c = 0; c < 3; c++) begin
         r = (mag[c] * y + (64'd1 << (k - 1))) >> k;
         if (r > 16384) r = 16384;
         comp_out[c] = (v[c] < 0) ? -DIR_W'(r) : DIR_W'(r);
      end
      d = '{dx: comp_out[0], dy: comp_out[1], dz: comp_out[2], deg: 1'b0};
      return d;
   endfunction

   // send one coordinate beat; entered and left at a falling edge
   task automatic send_ray(logic signed [SCREEN_W-1:0] sx,
                           logic signed [SCREEN_W-1:0] sy);
      while ($urandom_range(99) < send_gap_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_screen_x = sx;
      req_screen_y = sy;
      do @(posedge clock); while (busy);
      pending_dirs.push_back(predict_dir(sx, sy));
      @(negedge clock);
      start = 1'b0;
   endtask

   // register write; waits until the pipeline is empty
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [VEC_W-1:0] val);
      while (pending_dirs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_FORWARD: cam_forward = val;
         REG_RIGHT:   cam_right   = val;
         REG_UP:      cam_up      = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [VEC_W-1:0] pack_vec(int cx, int cy, int cz);
      return {COMP_W'(cz), COMP_W'(cy), COMP_W'(cx)};
   endfunction

   // random vector, components often at the extremes
   function automatic logic [VEC_W-1:0] random_vec();
      logic [VEC_W-1:0] vec;
      for (int c = 0; c < 3; c++) begin
         case ($urandom_range(5))
            0: vec[COMP_W*c +: COMP_W] = 20'h7FFFF;
            1: vec[COMP_W*c +: COMP_W] = 20'h80000;
            2: vec[COMP_W*c +: COMP_W] = '0;
            3: vec[COMP_W*c +: COMP_W] = COMP_W'($urandom_range(32768) - 16384);
            default: vec[COMP_W*c +: COMP_W] = COMP_W'($urandom);
         endcase
      end
      return vec;
   endfunction

   // corners of the screen, zero camera, unused register index, cancelled, extreme and tiny vectors
   task automatic test_directed();
      write_reg(REG_UNUSED, '1);
      send_ray(16'sd0, 16'sd0);                 // all registers zero
      send_ray(16'sd16384, -16'sd16384);
      write_reg(REG_FORWARD, pack_vec(0, 0, 16384));
      write_reg(REG_RIGHT, pack_vec(16384, 0, 0));
      write_reg(REG_UP, pack_vec(0, 16384, 0));
      write_reg(REG_UNUSED, '0);
      send_ray(16'sd0, 16'sd0);
      send_ray(16'sd16384, 16'sd16384);
      send_ray(-16'sd16384, -16'sd16384);
      send_ray(16'sd16384, -16'sd16384);
      send_ray(16'sd32767, -16'sd32768);
      send_ray(-16'sd32768, 16'sd32767);
      send_ray(16'sd1, -16'sd1);
      // forward cancelled by the right axis
      write_reg(REG_FORWARD, pack_vec(16384, 0, 0));
      send_ray(16'sd16384, 16'sd0);
      // extreme components
      write_reg(REG_FORWARD, {3{20'h7FFFF}});
      write_reg(REG_RIGHT, {3{20'h80000}});
      write_reg(REG_UP, {3{20'h7FFFF}});
      send_ray(-16'sd32768, -16'sd32768);
      send_ray(16'sd32767, 16'sd32767);
      send_ray(16'sd32767, -16'sd32768);
      // tiny vector
      write_reg(REG_FORWARD, pack_vec(1, 0, 0));
      write_reg(REG_RIGHT, '0);
      write_reg(REG_UP, '0);
      send_ray(16'sd123, -16'sd77);
   endtask

   // random camera setups, each followed by a burst of rays
   task automatic test_random_rays(int setups, int rays_per_setup, int gap_pct);
      logic signed [SCREEN_W-1:0] sx, sy;
      send_gap_pct = gap_pct;
      for (int n = 0; n < setups; n++) begin
         write_reg(REG_FORWARD, random_vec());
         write_reg(REG_RIGHT, random_vec());
         write_reg(REG_UP, random_vec());
         if ($urandom_range(3) == 0) write_reg(REG_UNUSED, VEC_W'({$urandom, $urandom}));
         for (int i = 0; i < rays_per_setup; i++) begin
            if ($urandom_range(9) == 0) begin
               sx = SCREEN_W'($urandom);
               sy = SCREEN_W'($urandom);
            end else begin
               sx = SCREEN_W'($urandom_range(32768) - 16384);
               sy = SCREEN_W'($urandom_range(32768) - 16384);
            end
            send_ray(sx, sy);
         end
      end
   endtask

   // result checker: one beat per strobe, oldest expectation first
   always @(posedge clock) begin
      ray_dir_type want;
      if (!reset && rsp_valid) begin
         if (pending_dirs.size() == 0) begin
            $display("%0t: unexpected result beat x=%0d y=%0d z=%0d deg=%0b", $time,
                     rsp_dir_x, rsp_dir_y, rsp_dir_z, rsp_degenerate);
            mismatch_count++;
         end else begin
            want = pending_dirs.pop_front();
            if (want.dx !== rsp_dir_x || want.dy !== rsp_dir_y ||
                want.dz !== rsp_dir_z || want.deg !== rsp_degenerate) begin
               $display("%0t: expected x=%0d y=%0d z=%0d deg=%0b got x=%0d y=%0d z=%0d deg=%0b",
                        $time, want.dx, want.dy, want.dz, want.deg,
                        rsp_dir_x, rsp_dir_y, rsp_dir_z, rsp_degenerate);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("camera_ray_direction_top verification failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_directed();
      test_random_rays(4, 135, 12);
      test_random_rays(4, 135, 58);
      test_random_rays(4, 135, 0);
      while (pending_dirs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_dirs.size() == 0)
         $display("camera_ray_direction_top verification clean");
      else
         $display("camera_ray_direction_top verification failed");
      $finish;
   end

endmodule

FILE: camera_ray_direction_top.f
hdl/crd_pkg.sv
hdl/camera_ray_direction_top.sv
bench/tb.sv
